// File: hw/rtl/hsl_saturation_adjust_defines.svh
`ifndef HSL_SATURATION_ADJUST_DEFINES_SVH
`define HSL_SATURATION_ADJUST_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define HSA_CHECK(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition that must hold in the cycle after the antecedent.
`define HSA_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/hsa_pkg.sv
package hsa_pkg;

    localparam int CHAN_W = 8;
    localparam int PCT_W  = 10;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Channel that holds the maximum, ties go red, then green, then blue
    typedef enum logic [1:0] {
        HSEL_RED,
        HSEL_GREEN,
        HSEL_BLUE
    } hsel_t;

    // Hue sectors
    localparam logic [2:0] SEC_R_Y = 3'd0;
    localparam logic [2:0] SEC_Y_G = 3'd1;
    localparam logic [2:0] SEC_G_C = 3'd2;
    localparam logic [2:0] SEC_C_B = 3'd3;
    localparam logic [2:0] SEC_B_M = 3'd4;
    localparam logic [2:0] SEC_M_R = 3'd5;

endpackage

// File: hw/rtl/hsa_div.sv
module hsa_div #(
    parameter int NW     = 18,
    parameter int QW     = 17,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NW-1:0]     sat_num,
    input  logic [NW-1:0]     sat_den,
    input  logic [NW-1:0]     hue_num,
    input  logic [NW-1:0]     hue_den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QW-1:0]     sat_q,
    output logic [QW-1:0]     hue_q,
    output logic [SIDE_W-1:0] side_out
);

    // Two restoring dividers in lockstep, one quotient bit per stage.
    // The numerator never exceeds the divisor, so the first stage compares and subtracts without shifting.
    logic [NW-1:0]     rem_reg  [2][QW];
    logic [NW-1:0]     den_reg  [2][QW];
    logic [QW-1:0]     q_reg    [2][QW];
    logic [NW-1:0]     rem_next [2][QW];
    logic [NW-1:0]     den_next [2][QW];
    logic [QW-1:0]     q_next   [2][QW];
    logic              valid_reg [QW];
    logic [SIDE_W-1:0] side_reg  [QW];

    always_comb
    begin
        logic [NW:0] trial;
        logic        ge;
        for (int ln = 0; ln < 2; ln++)
        begin
            for (int st = 0; st < QW; st++)
            begin
                if (st == 0)
                begin
                    trial             = {1'b0, (ln == 0) ? sat_num : hue_num};
                    den_next[ln][st]  = (ln == 0) ? sat_den : hue_den;
                    q_next[ln][st]    = '0;
                end
                else
                begin
                    trial             = {rem_reg[ln][st-1], 1'b0};
                    den_next[ln][st]  = den_reg[ln][st-1];
                    q_next[ln][st]    = q_reg[ln][st-1];
                end
                ge = trial >= {1'b0, den_next[ln][st]};
                rem_next[ln][st] = ge ? NW'(trial - {1'b0, den_next[ln][st]})
                                      : trial[NW-1:0];
                q_next[ln][st][QW-1-st] = ge;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int st = 0; st < QW; st++)
            begin
                valid_reg[st] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int st = 1; st < QW; st++)
            begin
                valid_reg[st] <= valid_reg[st-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int st = 1; st < QW; st++)
            begin
                side_reg[st] <= side_reg[st-1];
            end
            for (int ln = 0; ln < 2; ln++)
            begin
                for (int st = 0; st < QW; st++)
                begin
                    rem_reg[ln][st] <= rem_next[ln][st];
                    den_reg[ln][st] <= den_next[ln][st];
                    q_reg[ln][st]   <= q_next[ln][st];
                end
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign sat_q     = q_reg[0][QW-1];
    assign hue_q     = q_reg[1][QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

// File: hw/rtl/hsl_saturation_adjust.sv
// HSL saturation adjust: each RGB pixel is taken to HSL in fixed point with
// FRAC_BITS fraction bits, its saturation is scaled by 1 + saturation_percent/100
// and clamped to [0,1], and the pixel is converted back to 8-bit RGB, truncated.
// One pixel is accepted per clock while in_stall is low; the saturation and hue
// dividers resolve one quotient bit per stage. in_stall rises only while the
// output register holds a pixel and out_stall is high; the whole pipeline then
// holds. saturation_percent is written through the cfg channel (cfg_ready is
// always high) and must change only while no pixel is in flight.
`include "hsl_saturation_adjust_defines.svh"

module hsl_saturation_adjust #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [hsa_pkg::PCT_W-1:0]   saturation_percent,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [hsa_pkg::CHAN_W-1:0]  red_in,
    input  logic [hsa_pkg::CHAN_W-1:0]  green_in,
    input  logic [hsa_pkg::CHAN_W-1:0]  blue_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [hsa_pkg::CHAN_W-1:0]  red_out,
    output logic [hsa_pkg::CHAN_W-1:0]  green_out,
    output logic [hsa_pkg::CHAN_W-1:0]  blue_out
);

    localparam int F      = FRAC_BITS;
    localparam int VW     = F + 1;      // 0..ONE
    localparam int SW     = F + 2;      // 0..2*ONE
    localparam int HW     = F + 3;      // hue sector value
    localparam int GW     = F + 4;      // signed gain
    localparam int CPW    = F + 17;
    localparam int GPW    = F + 21;
    localparam int SPW    = 2 * F + 4;
    localparam int SIDE_W = VW + 4;

    localparam logic [VW-1:0]  ONE_V  = {1'b1, {F{1'b0}}};
    localparam logic [VW-1:0]  HALF_V = {2'b01, {(F-1){1'b0}}};
    localparam logic [SW-1:0]  TWO_S  = {2'b10, {F{1'b0}}};
    localparam logic [HW-1:0]  TWO_H  = {3'b010, {F{1'b0}}};
    localparam logic [HW-1:0]  FOUR_H = {3'b100, {F{1'b0}}};
    localparam logic [HW-1:0]  SIX_H  = {3'b110, {F{1'b0}}};
    localparam logic [CPW-1:0] CH_M   =
        CPW'(((64'd1 << (FRAC_BITS + 16)) + 64'd254) / 64'd255);
    localparam logic [GPW-1:0] G_M    =
        GPW'(((64'd1 << (FRAC_BITS + 17)) + 64'd99) / 64'd100);

    logic en;
    assign en        = !out_valid || !out_stall;
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    // Gain register, 3.F signed, worked out when the percent is written
    logic signed [GW-1:0]      gain_reg;
    logic signed [GW-1:0]      gain_next;
    logic [hsa_pkg::PCT_W-1:0] pct_abs;
    logic [GPW-1:0]            g_prod;
    logic [F+2:0]              g_q;
    logic                      gain_pos;

    always_comb
    begin
        pct_abs   = saturation_percent[hsa_pkg::PCT_W-1] ? (~saturation_percent + 1'b1)
                                                         : saturation_percent;
        g_prod    = GPW'(pct_abs) * G_M;
        g_q       = g_prod[F+19:17];
        gain_next = saturation_percent[hsa_pkg::PCT_W-1] ? GW'(ONE_V) - GW'(g_q)
                                                         : GW'(ONE_V) + GW'(g_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GW'(ONE_V);
        end
        else if (cfg_valid)
        begin
            gain_reg <= gain_next;
        end
    end

    assign gain_pos = !gain_reg[GW-1] && (gain_reg != '0);

    // Stage 0: channels to fixed point
    logic          s0_valid_reg;
    logic [VW-1:0] s0_r_reg, s0_g_reg, s0_b_reg;
    logic [CPW-1:0] r_prod, g_prod_c, b_prod;

    always_comb
    begin
        r_prod   = CPW'(red_in) * CH_M;
        g_prod_c = CPW'(green_in) * CH_M;
        b_prod   = CPW'(blue_in) * CH_M;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_r_reg <= r_prod[F+16:16];
            s0_g_reg <= g_prod_c[F+16:16];
            s0_b_reg <= b_prod[F+16:16];
        end
    end

    // Stage 1: max, min, lightness, divisors, hue numerator
    logic           s1_valid_reg;
    logic [VW-1:0]  s1_l_reg, s1_delta_reg, s1_hnum_reg;
    logic [SW-1:0]  s1_den_reg;
    logic           s1_gray_reg, s1_hneg_reg;
    hsa_pkg::hsel_t s1_hsel_reg;

    logic [VW-1:0]  mx, mn, hnum, l_next;
    logic [SW-1:0]  sum, den_next;
    logic           hneg;
    hsa_pkg::hsel_t hsel;

    always_comb
    begin
        if (s0_r_reg >= s0_g_reg && s0_r_reg >= s0_b_reg)
        begin
            hsel = hsa_pkg::HSEL_RED;
            mx   = s0_r_reg;
            hneg = s0_g_reg < s0_b_reg;
            hnum = hneg ? s0_b_reg - s0_g_reg : s0_g_reg - s0_b_reg;
        end
        else if (s0_g_reg >= s0_b_reg)
        begin
            hsel = hsa_pkg::HSEL_GREEN;
            mx   = s0_g_reg;
            hneg = s0_b_reg < s0_r_reg;
            hnum = hneg ? s0_r_reg - s0_b_reg : s0_b_reg - s0_r_reg;
        end
        else
        begin
            hsel = hsa_pkg::HSEL_BLUE;
            mx   = s0_b_reg;
            hneg = s0_r_reg < s0_g_reg;
            hnum = hneg ? s0_g_reg - s0_r_reg : s0_r_reg - s0_g_reg;
        end
        mn = s0_r_reg;
        if (s0_g_reg < mn)
        begin
            mn = s0_g_reg;
        end
        if (s0_b_reg < mn)
        begin
            mn = s0_b_reg;
        end
        sum      = SW'(mx) + SW'(mn);
        l_next   = sum[SW-1:1];
        den_next = (l_next < HALF_V) ? sum : TWO_S - sum;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_l_reg     <= l_next;
            s1_delta_reg <= mx - mn;
            s1_hnum_reg  <= hnum;
            s1_den_reg   <= den_next;
            s1_gray_reg  <= (mx == mn);
            s1_hneg_reg  <= hneg;
            s1_hsel_reg  <= hsel;
        end
    end

    // Dividers: saturation = delta/den, hue fraction = |diff|/delta
    logic              d_valid;
    logic [VW-1:0]     d_sat_q, d_hue_q;
    logic [SIDE_W-1:0] d_side;

    hsa_div #(
        .NW     (SW),
        .QW     (VW),
        .SIDE_W (SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .sat_num   (SW'(s1_delta_reg)),
        .sat_den   (s1_den_reg),
        .hue_num   (SW'(s1_hnum_reg)),
        .hue_den   (SW'(s1_delta_reg)),
        .side_in   ({s1_l_reg, s1_gray_reg, s1_hneg_reg, s1_hsel_reg}),
        .out_valid (d_valid),
        .sat_q     (d_sat_q),
        .hue_q     (d_hue_q),
        .side_out  (d_side)
    );

    // P1: clamp saturation, place hue in its sector
    logic           p1_valid_reg;
    logic [VW-1:0]  p1_s_reg, p1_l_reg;
    logic [HW-1:0]  p1_h_reg;
    logic [VW-1:0]  s_clamp;
    logic [HW-1:0]  h_next;
    logic [HW-1:0]  q_h;
    hsa_pkg::hsel_t d_hsel;
    logic           d_gray, d_hneg;

    always_comb
    begin
        d_hsel  = hsa_pkg::hsel_t'(d_side[1:0]);
        d_hneg  = d_side[2];
        d_gray  = d_side[3];
        q_h     = HW'(d_hue_q);
        s_clamp = (d_sat_q > ONE_V) ? ONE_V : d_sat_q;
        case (d_hsel)
            hsa_pkg::HSEL_RED:   h_next = d_hneg ? SIX_H - q_h : q_h;
            hsa_pkg::HSEL_GREEN: h_next = d_hneg ? TWO_H - q_h : TWO_H + q_h;
            hsa_pkg::HSEL_BLUE:  h_next = d_hneg ? FOUR_H - q_h : FOUR_H + q_h;
            default:             h_next = '0;
        endcase
        if (d_gray)
        begin
            s_clamp = '0;
            h_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_s_reg <= s_clamp;
            p1_h_reg <= h_next;
            p1_l_reg <= d_side[SIDE_W-1:4];
        end
    end

    // P2: apply gain, lightness weight 1 - |2l - 1|
    logic          p2_valid_reg;
    logic [VW-1:0] p2_s_reg, p2_t_reg, p2_l_reg;
    logic [HW-1:0] p2_h_reg;
    logic [SPW-1:0] sg_prod;
    logic [F+3:0]   sg_sh;
    logic [VW-1:0]  s2_next;
    logic [SW-1:0]  two_l, l_dev;

    always_comb
    begin
        sg_prod = SPW'(p1_s_reg) * SPW'(gain_reg[GW-2:0]);
        sg_sh   = sg_prod[SPW-1:F];
        if (!gain_pos)
        begin
            s2_next = '0;
        end
        else if (sg_sh > (F+4)'(ONE_V))
        begin
            s2_next = ONE_V;
        end
        else
        begin
            s2_next = sg_sh[VW-1:0];
        end
        two_l = {p1_l_reg, 1'b0};
        l_dev = (two_l >= SW'(ONE_V)) ? two_l - SW'(ONE_V) : SW'(ONE_V) - two_l;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_s_reg <= s2_next;
            p2_t_reg <= ONE_V - l_dev[VW-1:0];
            p2_h_reg <= p1_h_reg;
            p2_l_reg <= p1_l_reg;
        end
    end

    // P3: chroma, hue ramp, sector
    logic          p3_valid_reg;
    logic [VW-1:0] p3_c_reg, p3_ht_reg, p3_l_reg;
    logic [2:0]    p3_sec_reg;
    logic [2*VW-1:0] c_prod;
    logic [VW-1:0]   hm, hd;
    logic [2:0]      sec_raw;

    always_comb
    begin
        c_prod  = (2*VW)'(p2_t_reg) * (2*VW)'(p2_s_reg);
        hm      = p2_h_reg[VW-1:0];
        hd      = (hm >= ONE_V) ? hm - ONE_V : ONE_V - hm;
        sec_raw = p2_h_reg[HW-1:F];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_c_reg   <= c_prod[2*F:F];
            p3_ht_reg  <= ONE_V - hd;
            p3_sec_reg <= (sec_raw > hsa_pkg::SEC_M_R) ? hsa_pkg::SEC_M_R : sec_raw;
            p3_l_reg   <= p2_l_reg;
        end
    end

    // P4: second component and offset
    logic                 p4_valid_reg;
    logic [VW-1:0]        p4_c_reg, p4_x_reg;
    logic signed [SW-1:0] p4_m_reg;
    logic [2:0]           p4_sec_reg;
    logic [2*VW-1:0]      x_prod;

    assign x_prod = (2*VW)'(p3_c_reg) * (2*VW)'(p3_ht_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_c_reg   <= p3_c_reg;
            p4_x_reg   <= x_prod[2*F:F];
            p4_m_reg   <= SW'(p3_l_reg) - SW'(p3_c_reg >> 1);
            p4_sec_reg <= p3_sec_reg;
        end
    end

    // P5: pick primes by sector, add offset, floor at zero
    logic          p5_valid_reg;
    logic [SW-1:0] p5_sr_reg, p5_sg_reg, p5_sb_reg;
    logic [VW-1:0] pr, pg, pb;

    function automatic logic [SW-1:0] add_base(input logic [VW-1:0] prime,
                                               input logic [SW-1:0] m);
        logic [SW:0] t;
        t = {2'b00, prime} + {m[SW-1], m};
        return t[SW] ? '0 : t[SW-1:0];
    endfunction

    always_comb
    begin
        case (p4_sec_reg)
            hsa_pkg::SEC_R_Y:
            begin
                pr = p4_c_reg;
                pg = p4_x_reg;
                pb = '0;
            end
            hsa_pkg::SEC_Y_G:
            begin
                pr = p4_x_reg;
                pg = p4_c_reg;
                pb = '0;
            end
            hsa_pkg::SEC_G_C:
            begin
                pr = '0;
                pg = p4_c_reg;
                pb = p4_x_reg;
            end
            hsa_pkg::SEC_C_B:
            begin
                pr = '0;
                pg = p4_x_reg;
                pb = p4_c_reg;
            end
            hsa_pkg::SEC_B_M:
            begin
                pr = p4_x_reg;
                pg = '0;
                pb = p4_c_reg;
            end
            default:
            begin
                pr = p4_c_reg;
                pg = '0;
                pb = p4_x_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_sr_reg <= add_base(pr, p4_m_reg);
            p5_sg_reg <= add_base(pg, p4_m_reg);
            p5_sb_reg <= add_base(pb, p4_m_reg);
        end
    end

    // Output register: scale to 0..255, truncate and clamp
    logic                       out_valid_reg;
    logic [hsa_pkg::CHAN_W-1:0] red_out_reg, green_out_reg, blue_out_reg;

    function automatic logic [hsa_pkg::CHAN_W-1:0] to_byte(input logic [SW-1:0] v);
        logic [SW+7:0] prod;
        logic [9:0]    sh;
        prod = {v, 8'b0} - {8'b0, v};
        sh   = prod[SW+7:F];
        return (sh > 10'(hsa_pkg::CHAN_MAX)) ? hsa_pkg::CHAN_MAX : sh[7:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_out_reg   <= to_byte(p5_sr_reg);
            green_out_reg <= to_byte(p5_sg_reg);
            blue_out_reg  <= to_byte(p5_sb_reg);
        end
    end

    // Valid bits travel with the data and hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            p5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg  <= in_valid;
            s1_valid_reg  <= s0_valid_reg;
            p1_valid_reg  <= d_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            p4_valid_reg  <= p3_valid_reg;
            p5_valid_reg  <= p4_valid_reg;
            out_valid_reg <= p5_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;

    `HSA_CHECK(a_m_nonneg, !p4_valid_reg || !p4_m_reg[SW-1], "offset m went negative")
    `HSA_CHECK(a_c_le_one, !p3_valid_reg || (p3_c_reg <= ONE_V), "chroma above one")
    `HSA_CHECK_NEXT(a_p5_hold, !en && p5_valid_reg, p5_valid_reg && $stable(p5_sr_reg), "hold")

endmodule
